[rtl/assert_macros.svh]
// Assertion helpers for the page cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RPCM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define RPCM_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define RPCM_ASSERT(lbl, clk, rstn, prop)
`define RPCM_NEVER(lbl, clk, rstn, expr)
`endif
`endif

[rtl/rpcm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpcm_pkg
// Shared constants and codes for the page cache manager.
// ----------------------------------------------------------------------------
package rpcm_pkg;
    localparam int KEY_BITS   = 8;
    localparam int TYPE_BITS  = 2;
    localparam int SLOT_BITS  = KEY_BITS + TYPE_BITS;
    localparam int SLOTS      = 1 << SLOT_BITS;
    localparam int PAGE_TYPES = 1 << TYPE_BITS;
    localparam int COUNT_BITS = 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam int ENTRY_BITS = COUNT_BITS + 2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_PAST_END  = 3'd1;
    localparam logic [2:0] ST_UNREF     = 3'd2;
    localparam logic [2:0] ST_NO_ROOM   = 3'd3;
    localparam logic [2:0] ST_CNT_FULL  = 3'd4;

    localparam logic [1:0] MODE_ACQUIRE = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;

    localparam logic [2:0] REG_PAGE_SIZE    = 3'd0;
    localparam logic [2:0] REG_MAX_RESIDENT = 3'd1;
    localparam logic [2:0] REG_TOTAL_POS    = 3'd2;
    localparam logic [2:0] REG_TOTAL_COLOR  = 3'd3;
    localparam logic [2:0] REG_TOTAL_NORMAL = 3'd4;
    localparam logic [2:0] REG_TOTAL_INDEX  = 3'd5;
endpackage

[rtl/rpcm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpcm_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rpcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/refcounted_page_cache_manager_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_page_cache_manager_top
// Reference counted page residency manager with FIFO eviction of released
// pages, four page types.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps its 1024 entry state memory with busy
// high; configuration writes are taken during that time. A command beat is
// taken when start is high and busy low; the entry, prev and next memories
// are read at that edge. Busy then stays high while the entry is modified
// and written back, and through the evict state when an acquire evicts a
// page, because the victim's link must be read from the next-link memory
// first. The result sits on the outputs with o_valid high for exactly one
// cycle, starting at the edge that ends the busy time, and must be captured
// then: there is no back pressure. No new beat is taken before the last is
// written back. Configuration must be written by the user only while busy
// is low and no result is pending; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module refcounted_page_cache_manager_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [1:0]  i_page_type,
    input  logic [7:0]  i_page_key,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic        o_was_resident,
    output logic        o_load_needed,
    output logic        o_evicted_valid,
    output logic [7:0]  o_evicted_key,
    output logic [27:0] o_element_start,
    output logic [20:0] o_element_count,
    output logic [7:0]  o_reference_count,
    output logic        o_referenced,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [28:0] i_cfg_data
);
    localparam int KB = rpcm_pkg::KEY_BITS;
    localparam int SB = rpcm_pkg::SLOT_BITS;
    localparam int CB = rpcm_pkg::COUNT_BITS;
    localparam int EB = rpcm_pkg::ENTRY_BITS;
    localparam int NT = rpcm_pkg::PAGE_TYPES;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_EVICT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [20:0] r_page_size;
    logic [8:0]  r_max_res;
    logic [28:0] r_total [NT];

    // per type release order and residency bookkeeping
    logic [KB-1:0] r_head [NT];
    logic [KB-1:0] r_tail [NT];
    logic [8:0]    r_len  [NT];
    logic [8:0]    r_tot  [NT];
    logic [KB-1:0] n_head, n_tail;
    logic [8:0]    n_len, n_tot;
    logic          n_tbl_we;

    // latched command
    logic [1:0]    r_mode;
    logic [1:0]    r_t;
    logic [KB-1:0] r_k;
    logic [28:0]   r_start;
    logic [SB-1:0] r_clr;

    // memory ports
    logic          a_we;
    logic [SB-1:0] a_waddr, a_raddr;
    logic [EB-1:0] a_wdata, a_rdata;
    logic          nx_we, pv_we;
    logic [SB-1:0] nx_waddr, pv_waddr, nx_raddr;
    logic [KB-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;

    // result registers
    logic          r_valid, n_valid;
    logic [2:0]    r_status, n_status;
    logic          r_was_res, n_was_res, r_load, n_load, r_ev_v, n_ev_v;
    logic [KB-1:0] r_ev_key, n_ev_key;
    logic [27:0]   r_el_start, n_el_start;
    logic [20:0]   r_el_cnt, n_el_cnt;
    logic [CB-1:0] r_cnt_out, n_cnt_out;
    logic          n_res_upd;

    logic          accept;
    logic [28:0]   w_prod, w_rest, w_tot_cfg;
    logic [CB-1:0] w_cnt;
    logic          w_res, w_ino;
    logic [KB-1:0] w_head, w_tail;
    logic [8:0]    w_len, w_tot;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign w_prod    = {21'd0, i_page_key} * {8'd0, r_page_size};
    assign {w_cnt, w_res, w_ino} = a_rdata;
    assign w_head    = r_head[r_t];
    assign w_tail    = r_tail[r_t];
    assign w_len     = r_len[r_t];
    assign w_tot     = r_tot[r_t];
    assign w_tot_cfg = r_total[r_t];
    assign w_rest    = w_tot_cfg - r_start;

    rpcm_ram #(.WIDTH(EB), .DEPTH(rpcm_pkg::SLOTS)) u_entry (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_raddr(a_raddr), .o_rdata(a_rdata)
    );
    rpcm_ram #(.WIDTH(KB), .DEPTH(rpcm_pkg::SLOTS)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_raddr(nx_raddr), .o_rdata(nx_rdata)
    );
    rpcm_ram #(.WIDTH(KB), .DEPTH(rpcm_pkg::SLOTS)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_waddr), .i_wdata(pv_wdata),
        .i_raddr(a_raddr), .o_rdata(pv_rdata)
    );

    assign a_raddr  = {i_page_type, i_page_key};
    // in READ the next-link read fetches the current head's successor
    assign nx_raddr = (r_state == S_READ) ? {r_t, w_head} : a_raddr;

    always_comb begin
        n_state   = r_state;
        a_we      = 1'b0;
        a_waddr   = {r_t, r_k};
        a_wdata   = '0;
        nx_we     = 1'b0;
        nx_waddr  = {r_t, w_tail};
        nx_wdata  = r_k;
        pv_we     = 1'b0;
        pv_waddr  = {r_t, r_k};
        pv_wdata  = w_tail;
        n_head    = w_head;
        n_tail    = w_tail;
        n_len     = w_len;
        n_tot     = w_tot;
        n_tbl_we  = 1'b0;
        n_valid   = 1'b0;
        n_res_upd = 1'b0;
        n_status  = rpcm_pkg::ST_OK;
        n_was_res = 1'b0;
        n_load    = 1'b0;
        n_ev_v    = 1'b0;
        n_ev_key  = '0;
        n_el_start = '0;
        n_el_cnt  = '0;
        n_cnt_out = w_cnt;
        unique case (r_state)
            S_CLEAR: begin
                a_we    = 1'b1;
                a_waddr = r_clr;
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state   = S_IDLE;
                n_valid   = 1'b1;
                n_res_upd = 1'b1;
                n_tbl_we  = 1'b1;
                if (r_mode == rpcm_pkg::MODE_ACQUIRE) begin
                    priority if (r_start >= w_tot_cfg) begin
                        n_status = rpcm_pkg::ST_PAST_END;
                    end else if (w_cnt == rpcm_pkg::COUNT_MAX) begin
                        n_status = rpcm_pkg::ST_CNT_FULL;
                    end else if (!w_res && w_tot >= r_max_res && w_len == '0) begin
                        n_status = rpcm_pkg::ST_NO_ROOM;
                    end else begin
                        n_cnt_out  = w_cnt + 1'b1;
                        a_we       = 1'b1;
                        a_wdata    = {w_cnt + 1'b1, 1'b1, 1'b0};
                        n_el_start = r_start[27:0];
                        n_el_cnt   = (w_rest < {8'd0, r_page_size}) ? w_rest[20:0]
                                                                    : r_page_size;
                        if (w_ino) begin
                            // unlink this page from the release order
                            if (w_len <= 9'd1) begin
                                n_len = '0;
                            end else begin
                                if (r_k == w_head) begin
                                    n_head = nx_rdata;
                                end else if (r_k == w_tail) begin
                                    n_tail = pv_rdata;
                                end else begin
                                    nx_we    = 1'b1;
                                    nx_waddr = {r_t, pv_rdata};
                                    nx_wdata = nx_rdata;
                                    pv_we    = 1'b1;
                                    pv_waddr = {r_t, nx_rdata};
                                    pv_wdata = pv_rdata;
                                end
                                n_len = w_len - 1'b1;
                            end
                        end
                        if (w_res) begin
                            n_was_res = 1'b1;
                        end else begin
                            n_load = 1'b1;
                            if (w_tot >= r_max_res) begin
                                // victim link arrives next cycle
                                n_valid = 1'b0;
                                n_state = S_EVICT;
                            end else begin
                                n_tot = w_tot + 1'b1;
                            end
                        end
                    end
                end else if (r_mode == rpcm_pkg::MODE_RELEASE) begin
                    if (w_cnt == '0) begin
                        n_status = rpcm_pkg::ST_UNREF;
                    end else begin
                        n_cnt_out = w_cnt - 1'b1;
                        a_we      = 1'b1;
                        a_wdata   = {w_cnt - 1'b1, w_res, w_ino};
                        if (w_cnt == CB'(1) && !w_ino) begin
                            a_wdata = {w_cnt - 1'b1, w_res, 1'b1};
                            if (w_len == '0) begin
                                n_head = r_k;
                            end else begin
                                nx_we = 1'b1;
                                pv_we = 1'b1;
                            end
                            n_tail = r_k;
                            n_len  = w_len + 1'b1;
                        end
                    end
                end
            end
            S_EVICT: begin
                n_state  = S_IDLE;
                n_valid  = 1'b1;
                n_tbl_we = 1'b1;
                a_we     = 1'b1;
                a_waddr  = {r_t, w_head};
                if (w_len <= 9'd1) begin
                    n_len = '0;
                end else begin
                    n_head = nx_rdata;
                    n_len  = w_len - 1'b1;
                end
                n_tot = (w_tot == '0) ? 9'd1 : w_tot;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_valid     <= 1'b0;
            r_page_size <= 21'd1024;
            r_max_res   <= 9'd64;
            for (int j = 0; j < NT; j++) begin
                r_total[j] <= '0;
                r_len[j]   <= '0;
                r_tot[j]   <= '0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (n_tbl_we) begin
                r_len[r_t] <= n_len;
                r_tot[r_t] <= n_tot;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    rpcm_pkg::REG_PAGE_SIZE:    r_page_size <= i_cfg_data[20:0];
                    rpcm_pkg::REG_MAX_RESIDENT: r_max_res   <= i_cfg_data[8:0];
                    rpcm_pkg::REG_TOTAL_POS:    r_total[0]  <= i_cfg_data;
                    rpcm_pkg::REG_TOTAL_COLOR:  r_total[1]  <= i_cfg_data;
                    rpcm_pkg::REG_TOTAL_NORMAL: r_total[2]  <= i_cfg_data;
                    rpcm_pkg::REG_TOTAL_INDEX:  r_total[3]  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_mode;
            r_t     <= i_page_type;
            r_k     <= i_page_key;
            r_start <= w_prod;
        end
        if (n_tbl_we) begin
            r_head[r_t] <= n_head;
            r_tail[r_t] <= n_tail;
        end
        if (n_res_upd) begin
            r_status   <= n_status;
            r_was_res  <= n_was_res;
            r_load     <= n_load;
            r_el_start <= n_el_start;
            r_el_cnt   <= n_el_cnt;
            r_cnt_out  <= n_cnt_out;
            r_ev_v     <= 1'b0;
            r_ev_key   <= '0;
        end else if (r_state == S_EVICT) begin
            r_ev_v   <= 1'b1;
            r_ev_key <= w_head;
        end
    end

    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_was_resident    = r_was_res;
    assign o_load_needed     = r_load;
    assign o_evicted_valid   = r_ev_v;
    assign o_evicted_key     = r_ev_key;
    assign o_element_start   = r_el_start;
    assign o_element_count   = r_el_cnt;
    assign o_reference_count = r_cnt_out;
    assign o_referenced      = (r_cnt_out != '0);

    // results never come back to back
    `RPCM_ASSERT(a_strobe_gap, i_clk, i_rst_n, o_valid |=> !o_valid)
    // an eviction only happens on a miss
    `RPCM_NEVER(a_evict_on_miss, i_clk, i_rst_n, o_valid && o_evicted_valid && !o_load_needed)
    // hit and miss are exclusive
    `RPCM_NEVER(a_hit_xor_miss, i_clk, i_rst_n, o_valid && o_was_resident && o_load_needed)
    // a result follows the read or evict state of its command
    `RPCM_ASSERT(a_result_src, i_clk, i_rst_n, o_valid |-> ($past(r_state) == S_READ || $past(r_state) == S_EVICT))
endmodule
